[src/etu_pkg.sv]
`timescale 1ns / 1ps

package etu_pkg;

    localparam int BUCKETS   = 4096;
    localparam int CAPACITY  = 4096;
    localparam int BKT_W     = $clog2(BUCKETS);
    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int HEAD_W    = SLOT_W + 1;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [63:0] MIX_MULT  = 64'hff51afd7ed558ccd;
    localparam int          MIX_SHIFT = 33;
    localparam logic [15:0] Q_ONE     = 16'd32768;
    localparam logic [31:0] Q_HALF    = 32'd16384;

    localparam logic       KIND_ADD     = 1'b0;
    localparam logic       KIND_FIND    = 1'b1;
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_INSERTED  = 2'd1;
    localparam logic [1:0] ST_ABSENT    = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [31:0] src_id;
        logic [31:0] dst_id;
        logic [15:0] add_weight;
        logic [31:0] now_tick;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] slot;
        logic [15:0] weight_out;
        logic [31:0] last_active;
    } t_rsp;

    typedef struct packed {
        t_req             req;
        logic [BKT_W-1:0] bucket;
    } t_job;

endpackage

[src/etu_front.sv]
`timescale 1ns / 1ps

module etu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  etu_pkg::t_req i_req,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output etu_pkg::t_job o_job
);

    logic          r_v1, r_v2, r_v3;
    etu_pkg::t_req r_req1, r_req2, r_req3;
    logic [63:0]   r_x;
    logic [63:0]   r_p0;
    logic [31:0]   r_p1, r_p2;
    logic [63:0]   r_h;
    logic          adv;
    logic [63:0]   key;
    logic [63:0]   mixed;
    etu_pkg::t_req sat_req;

    assign adv     = !r_v3 || i_job_ready;
    assign o_ready = adv;
    assign key     = {i_req.src_id, i_req.dst_id};

    always_comb begin
        sat_req = i_req;
        if (i_req.add_weight > etu_pkg::Q_ONE) begin
            sat_req.add_weight = etu_pkg::Q_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_req1 <= sat_req;
            r_x    <= key ^ (key >> etu_pkg::MIX_SHIFT);
            r_req2 <= r_req1;
            r_p0   <= 64'(r_x[31:0]) * 64'(etu_pkg::MIX_MULT[31:0]);
            r_p1   <= r_x[63:32] * etu_pkg::MIX_MULT[31:0];
            r_p2   <= r_x[31:0] * etu_pkg::MIX_MULT[63:32];
            r_req3 <= r_req2;
            r_h    <= r_p0 + {r_p1 + r_p2, 32'd0};
        end
    end

    assign mixed       = r_h ^ (r_h >> etu_pkg::MIX_SHIFT);
    assign o_job_valid = r_v3;
    assign o_job.req   = r_req3;
    assign o_job.bucket = mixed[etu_pkg::BKT_W-1:0];

endmodule

[src/etu_queue.sv]
`timescale 1ns / 1ps

module etu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  etu_pkg::t_job i_data,
    output logic          o_valid,
    input  logic          i_pop,
    output etu_pkg::t_job o_data
);

    etu_pkg::t_job                  r_mem [etu_pkg::QDEPTH];
    logic [etu_pkg::QPTR_W-1:0]     r_wr, r_rd;
    logic [etu_pkg::QPTR_W:0]       r_cnt;
    logic                           push, pop;

    assign o_ready = r_cnt != (etu_pkg::QPTR_W + 1)'(etu_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (etu_pkg::QPTR_W + 1)'(push) - (etu_pkg::QPTR_W + 1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[src/etu_back.sv]
`timescale 1ns / 1ps

module etu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_pop,
    input  etu_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output etu_pkg::t_rsp o_rsp
);

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] weight;
        logic [31:0] stamp;
    } t_rec;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HEAD  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;

    logic [etu_pkg::HEAD_W-1:0] head_mem [etu_pkg::BUCKETS];
    logic [etu_pkg::HEAD_W-1:0] next_mem [etu_pkg::CAPACITY];
    t_rec                       rec_mem  [etu_pkg::CAPACITY];

    logic [2:0]                 r_state, n_state;
    logic [etu_pkg::BKT_W-1:0]  r_clr, n_clr;
    logic [etu_pkg::CNT_W-1:0]  r_count, n_count;
    etu_pkg::t_job              r_job, n_job;
    logic [etu_pkg::HEAD_W-1:0] r_head, n_head;
    logic [etu_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [15:0]                r_wt, n_wt;
    logic [31:0]                r_prod, n_prod;
    logic                       r_ov, n_ov;
    etu_pkg::t_rsp              r_rsp, n_rsp;

    logic [etu_pkg::HEAD_W-1:0] r_head_q, r_next_q;
    t_rec                       r_rec_q;

    logic                       out_free, link_ok, hit, miss;
    logic [etu_pkg::HEAD_W-1:0] link;
    logic [etu_pkg::SLOT_W-1:0] rd_slot;
    logic                       head_we, rec_we, next_we;
    logic [etu_pkg::BKT_W-1:0]  head_wa;
    logic [etu_pkg::HEAD_W-1:0] head_wd;
    logic [etu_pkg::SLOT_W-1:0] rec_wa;
    t_rec                       rec_wd;
    logic [15:0]                room;
    logic [16:0]                inc, nw;
    logic [15:0]                nw_sat;

    assign out_free  = !r_ov || i_ready;
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid && out_free;
    assign link      = (r_state == S_HEAD) ? r_head_q : r_next_q;
    assign rd_slot   = link[etu_pkg::SLOT_W-1:0];
    assign link_ok   = link[etu_pkg::SLOT_W]
                    && (etu_pkg::CNT_W'(rd_slot) < r_count);
    assign hit       = (r_rec_q.src == r_job.req.src_id) && (r_rec_q.dst == r_job.req.dst_id);
    assign miss      = ((r_state == S_HEAD) && !link_ok)
                    || ((r_state == S_CMP) && !hit && !link_ok);
    assign room      = (r_rec_q.weight < etu_pkg::Q_ONE) ? (etu_pkg::Q_ONE - r_rec_q.weight)
                                                         : 16'd0;
    assign inc       = 17'((r_prod + etu_pkg::Q_HALF) >> 15);
    assign nw        = {1'b0, r_wt} + inc;
    assign nw_sat    = (nw > {1'b0, etu_pkg::Q_ONE}) ? etu_pkg::Q_ONE : nw[15:0];

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_count = r_count;
        n_job   = r_job;
        n_head  = r_head;
        n_slot  = r_slot;
        n_wt    = r_wt;
        n_prod  = r_prod;
        n_ov    = r_ov && !i_ready;
        n_rsp   = r_rsp;
        head_we = 1'b0;
        head_wa = r_job.bucket;
        head_wd = '0;
        rec_we  = 1'b0;
        rec_wa  = r_slot;
        rec_wd  = '0;
        next_we = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                head_we = 1'b1;
                head_wa = r_clr;
                n_clr   = r_clr + 1'b1;
                if (r_clr == etu_pkg::BKT_W'(etu_pkg::BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_job_pop) begin
                    n_job   = i_job;
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                n_head = r_head_q;
                if (link_ok) begin
                    n_slot  = rd_slot;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (hit) begin
                    if (r_job.req.kind == etu_pkg::KIND_FIND) begin
                        n_ov    = 1'b1;
                        n_rsp   = '{etu_pkg::ST_FOUND, 12'(r_slot), r_rec_q.weight,
                                    r_rec_q.stamp};
                        n_state = S_IDLE;
                    end else begin
                        n_prod  = r_job.req.add_weight * room;
                        n_wt    = r_rec_q.weight;
                        n_state = S_MUL;
                    end
                end else if (link_ok) begin
                    n_slot = rd_slot;
                end
            end
            S_MUL: begin
                rec_we  = 1'b1;
                rec_wd  = '{r_job.req.src_id, r_job.req.dst_id, nw_sat, r_job.req.now_tick};
                n_ov    = 1'b1;
                n_rsp   = '{etu_pkg::ST_FOUND, 12'(r_slot), nw_sat, r_job.req.now_tick};
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (miss) begin
            n_ov    = 1'b1;
            n_state = S_IDLE;
            priority if (r_job.req.kind == etu_pkg::KIND_FIND) begin
                n_rsp = '{etu_pkg::ST_ABSENT, 12'd0, 16'd0, 32'd0};
            end else if (r_count == etu_pkg::CNT_W'(etu_pkg::CAPACITY)) begin
                n_rsp = '{etu_pkg::ST_FULL, 12'd0, 16'd0, 32'd0};
            end else begin
                rec_we  = 1'b1;
                next_we = 1'b1;
                head_we = 1'b1;
                rec_wa  = r_count[etu_pkg::SLOT_W-1:0];
                rec_wd  = '{r_job.req.src_id, r_job.req.dst_id, r_job.req.add_weight,
                            r_job.req.now_tick};
                head_wd = {1'b1, r_count[etu_pkg::SLOT_W-1:0]};
                n_count = r_count + 1'b1;
                n_rsp   = '{etu_pkg::ST_INSERTED, 12'(r_count), r_job.req.add_weight,
                            r_job.req.now_tick};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_head <= n_head;
        r_slot <= n_slot;
        r_wt   <= n_wt;
        r_prod <= n_prod;
        r_rsp  <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            head_mem[head_wa] <= head_wd;
        end
        r_head_q <= head_mem[i_job.bucket];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            next_mem[rec_wa] <= (r_state == S_HEAD) ? r_head_q : r_head;
        end
        r_next_q <= next_mem[rd_slot];
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            rec_mem[rec_wa] <= rec_wd;
        end
        r_rec_q <= rec_mem[rd_slot];
    end

    assign o_valid = r_ov;
    assign o_rsp   = r_rsp;

endmodule

[src/edge_table_upsert_top.sv]
`timescale 1ns / 1ps
// channel   direction  handshake           payload
// request   in         i_valid / o_ready   i_req (etu_pkg::t_req)
// response  out        o_valid / i_ready   o_rsp (etu_pkg::t_rsp)
//
// A request passes through the registered hash pipeline, then waits in a four-entry queue.
// The chain walker reads the bucket head, then compares one chain link per step until a hit
// or a miss at the end of the chain, with one registered read of the edge store per link.
// Insert and find need no extra state; a strengthening add needs one more for the multiply.
// After reset the walker sweeps all BUCKETS (4096) bucket heads empty; requests queue up.
// A pending response holds only the walker; the hash pipeline and queue keep taking requests until the queue is full.

module edge_table_upsert_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  etu_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output etu_pkg::t_rsp o_rsp
);

    logic          f_valid, f_ready, q_valid, q_pop;
    etu_pkg::t_job f_job, q_job;

    etu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job       (f_job)
    );

    etu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_job),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_job)
    );

    etu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_pop   (q_pop),
        .i_job       (q_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rsp       (o_rsp)
    );

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.weight_out <= etu_pkg::Q_ONE)
        else $error("weight above one");

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.status == etu_pkg::ST_ABSENT || o_rsp.status == etu_pkg::ST_FULL)
        |-> o_rsp.slot == 12'd0 && o_rsp.weight_out == 16'd0 && o_rsp.last_active == 32'd0)
        else $error("absent or full transfer carries data");

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("walker popped an empty queue");

endmodule

[tb/sv/edge_table_upsert_top_test.sv]
`timescale 1ns / 1ps

module edge_table_upsert_top_test;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    etu_pkg::t_req i_req = '0;
    logic o_ready;
    logic o_valid;
    etu_pkg::t_rsp o_rsp;

    edge_table_upsert_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(i_req), .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [etu_pkg::HEAD_W-1:0] head_tbl [etu_pkg::BUCKETS];
    logic [etu_pkg::HEAD_W-1:0] link_tbl [etu_pkg::CAPACITY];
    logic [31:0] src_tbl [etu_pkg::CAPACITY];
    logic [31:0] dst_tbl [etu_pkg::CAPACITY];
    logic [15:0] wgt_tbl [etu_pkg::CAPACITY];
    logic [31:0] stamp_tbl [etu_pkg::CAPACITY];
    int unsigned edges_used;

    etu_pkg::t_rsp rsp_due [$];
    int unsigned errors = 0;
    int unsigned sent = 0;
    int unsigned received = 0;
    int unsigned idle_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic [31:0] known_src [$];
    logic [31:0] known_dst [$];

    function automatic logic [etu_pkg::BKT_W-1:0] bucket_of(logic [31:0] s, logic [31:0] d);
        logic [63:0] h;
        h = {s, d};
        h = h ^ (h >> etu_pkg::MIX_SHIFT);
        h = h * etu_pkg::MIX_MULT;
        h = h ^ (h >> etu_pkg::MIX_SHIFT);
        return h[etu_pkg::BKT_W-1:0];
    endfunction

    function automatic etu_pkg::t_rsp upsert_predict(etu_pkg::t_req r);
        etu_pkg::t_rsp o;
        logic [etu_pkg::BKT_W-1:0] b;
        logic [etu_pkg::HEAD_W-1:0] cur;
        int unsigned steps, slot, w, room, inc, nw;
        bit hit;
        b = bucket_of(r.src_id, r.dst_id);
        cur = head_tbl[b];
        steps = 0;
        hit = 0;
        slot = 0;
        while (cur[etu_pkg::SLOT_W] && cur[etu_pkg::SLOT_W-1:0] < edges_used
               && steps < edges_used && !hit) begin
            if (src_tbl[cur[etu_pkg::SLOT_W-1:0]] == r.src_id
                && dst_tbl[cur[etu_pkg::SLOT_W-1:0]] == r.dst_id) begin
                hit = 1;
                slot = cur[etu_pkg::SLOT_W-1:0];
            end else begin
                cur = link_tbl[cur[etu_pkg::SLOT_W-1:0]];
                steps++;
            end
        end
        w = (r.add_weight > etu_pkg::Q_ONE) ? etu_pkg::Q_ONE : r.add_weight;
        o = '0;
        if (r.kind == etu_pkg::KIND_FIND) begin
            if (hit) begin
                o.status = etu_pkg::ST_FOUND;
                o.slot = 12'(slot);
                o.weight_out = wgt_tbl[slot];
                o.last_active = stamp_tbl[slot];
            end else begin
                o.status = etu_pkg::ST_ABSENT;
            end
        end else if (hit) begin
            room = (wgt_tbl[slot] < etu_pkg::Q_ONE) ? (etu_pkg::Q_ONE - wgt_tbl[slot]) : 0;
            inc = (w * room + etu_pkg::Q_HALF) >> 15;
            nw = wgt_tbl[slot] + inc;
            if (nw > etu_pkg::Q_ONE) nw = etu_pkg::Q_ONE;
            wgt_tbl[slot] = 16'(nw);
            stamp_tbl[slot] = r.now_tick;
            o.status = etu_pkg::ST_FOUND;
            o.slot = 12'(slot);
            o.weight_out = 16'(nw);
            o.last_active = r.now_tick;
        end else if (edges_used >= etu_pkg::CAPACITY) begin
            o.status = etu_pkg::ST_FULL;
        end else begin
            slot = edges_used;
            src_tbl[slot] = r.src_id;
            dst_tbl[slot] = r.dst_id;
            wgt_tbl[slot] = 16'(w);
            stamp_tbl[slot] = r.now_tick;
            link_tbl[slot] = head_tbl[b];
            head_tbl[b] = {1'b1, slot[etu_pkg::SLOT_W-1:0]};
            edges_used++;
            o.status = etu_pkg::ST_INSERTED;
            o.slot = 12'(slot);
            o.weight_out = 16'(w);
            o.last_active = r.now_tick;
        end
        return o;
    endfunction

    task automatic send_req(etu_pkg::t_req r);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req <= r;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        rsp_due.push_back(upsert_predict(r));
        sent++;
        if (r.kind == etu_pkg::KIND_ADD) begin
            known_src.push_back(r.src_id);
            known_dst.push_back(r.dst_id);
        end
        @(negedge i_clk);
    endtask

    function automatic etu_pkg::t_req make_req(logic k, logic [31:0] s, logic [31:0] d,
                                               logic [15:0] w, logic [31:0] t);
        etu_pkg::t_req r;
        r.kind = k;
        r.src_id = s;
        r.dst_id = d;
        r.add_weight = w;
        r.now_tick = t;
        return r;
    endfunction

    always @(negedge i_clk) begin
        i_ready <= (recv_idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        etu_pkg::t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            received++;
            if (rsp_due.size() == 0) begin
                $display("%0t: unexpected response %h", $time, o_rsp);
                errors++;
            end else begin
                want = rsp_due.pop_front();
                if (o_rsp.status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, o_rsp.status);
                    errors++;
                end
                if (o_rsp.slot !== want.slot) begin
                    $display("%0t: slot exp %0d got %0d", $time, want.slot, o_rsp.slot);
                    errors++;
                end
                if (o_rsp.weight_out !== want.weight_out) begin
                    $display("%0t: weight exp %0d got %0d", $time, want.weight_out,
                             o_rsp.weight_out);
                    errors++;
                end
                if (o_rsp.last_active !== want.last_active) begin
                    $display("%0t: stamp exp %h got %h", $time, want.last_active,
                             o_rsp.last_active);
                    errors++;
                end
            end
        end
    end

    // watchdog over cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_req(make_req(etu_pkg::KIND_FIND, 32'h0, 32'h0, 16'd0, 32'd1));
        send_req(make_req(etu_pkg::KIND_ADD, 32'h0, 32'h0, 16'd0, 32'd0));
        send_req(make_req(etu_pkg::KIND_ADD, 32'h0, 32'h0, 16'd16384, 32'd5));
        send_req(make_req(etu_pkg::KIND_ADD, 32'h0, 32'h0, 16'hFFFF, 32'hFFFFFFFF));
        send_req(make_req(etu_pkg::KIND_ADD, 32'h0, 32'h0, 16'd100, 32'd6));
        send_req(make_req(etu_pkg::KIND_FIND, 32'h0, 32'h0, 16'hFFFF, 32'd7));
        send_req(make_req(etu_pkg::KIND_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 32'd8));
        send_req(make_req(etu_pkg::KIND_ADD, 32'hFFFFFFFF, 32'h0, 16'd32768, 32'd9));
        send_req(make_req(etu_pkg::KIND_ADD, 32'h0, 32'hFFFFFFFF, 16'd32769, 32'd10));
        send_req(make_req(etu_pkg::KIND_ADD, 32'hAAAAAAAA, 32'h55555555, 16'd1, 32'd11));
        send_req(make_req(etu_pkg::KIND_ADD, 32'hAAAAAAAA, 32'h55555555, 16'd1, 32'd12));
        send_req(make_req(etu_pkg::KIND_FIND, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd0, 32'd0));
        send_req(make_req(etu_pkg::KIND_FIND, 32'h12345678, 32'h9ABCDEF0, 16'd0, 32'd0));
        send_req(make_req(etu_pkg::KIND_FIND, 32'h55555555, 32'hAAAAAAAA, 16'd0, 32'd0));
    endtask

    task automatic test_random(int unsigned n);
        etu_pkg::t_req r;
        int unsigned pick;
        for (int unsigned i = 0; i < n; i++) begin
            r.kind = $urandom_range(2) == 0 ? etu_pkg::KIND_FIND : etu_pkg::KIND_ADD;
            if (known_src.size() != 0 && $urandom_range(99) < 55) begin
                pick = $urandom_range(known_src.size() - 1);
                r.src_id = known_src[pick];
                r.dst_id = known_dst[pick];
            end else begin
                r.src_id = $urandom_range(3) == 0 ? $urandom_range(15) : $urandom;
                r.dst_id = $urandom_range(3) == 0 ? $urandom_range(15) : $urandom;
            end
            case ($urandom_range(3))
                0: r.add_weight = 16'($urandom);
                1: r.add_weight = etu_pkg::Q_ONE;
                default: r.add_weight = 16'($urandom_range(32768));
            endcase
            r.now_tick = $urandom;
            send_req(r);
        end
    endtask

    initial begin
        int unsigned guard;
        for (int i = 0; i < etu_pkg::BUCKETS; i++) head_tbl[i] = '0;
        edges_used = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 29;
        recv_idle_pct = 66;
        test_directed();
        test_random(450);
        send_idle_pct = 66;
        recv_idle_pct = 29;
        test_random(450);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(450);
        i_valid <= 1'b0;
        guard = 0;
        while (rsp_due.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (64) @(posedge i_clk);
        $display("Covered %0d requests and %0d responses, store holds %0d edges.",
                 sent, received, edges_used);
        if (errors == 0 && rsp_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
